[rtl/btc_pkg.sv]
// Shared types, constants and lookup functions for the binary/text classifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package btc_pkg;

	localparam int SAMPLE_LIMIT_DEF  = 512;
	localparam int MIN_EARLY_DEF     = 32;
	localparam int SLEN_W            = 10;
	localparam int TOTAL_W           = 10;
	localparam int AT_W              = 9;
	localparam int QUEUE_DEPTH       = 2;
	localparam int TOTAL_MAX         = (1 << TOTAL_W) - 1;
	localparam int RATIO_FACTOR      = 10;

	localparam logic [7:0] CHAR_PRINT_LO = 8'd32;
	localparam logic [7:0] CHAR_PRINT_HI = 8'd126;
	localparam logic [7:0] CHAR_DEL      = 8'd127;
	localparam logic [7:0] CHAR_WS_LO    = 8'd8;
	localparam logic [7:0] CHAR_WS_HI    = 8'd13;
	localparam logic [7:0] CHAR_NUL      = 8'd0;
	localparam logic [7:0] LEAD2_LO      = 8'hC2;
	localparam logic [7:0] LEAD3_LO      = 8'hE0;
	localparam logic [7:0] LEAD4_LO      = 8'hF0;
	localparam logic [7:0] LEAD_END      = 8'hF5;
	localparam logic [7:0] CONT_MASK     = 8'hC0;
	localparam logic [7:0] CONT_TAG      = 8'h80;

	typedef enum logic [2:0] {
		CAUSE_EMPTY = 3'd0,
		CAUSE_BOM   = 3'd1,
		CAUSE_PDF   = 3'd2,
		CAUSE_NUL   = 3'd3,
		CAUSE_EARLY = 3'd4,
		CAUSE_END   = 3'd5
	} cause_t;

	typedef struct packed {
		logic                 looks_binary;
		cause_t               cause;
		logic [TOTAL_W-1:0]   suspicious_total;
		logic [AT_W-1:0]      decided_at;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t item;
	} push_t;

	// UTF-8 byte order mark, one byte per index
	function automatic logic [7:0] bom_at(input logic [1:0] i);
		logic [7:0] b;
		unique case (i)
			2'd0:    b = 8'hEF;
			2'd1:    b = 8'hBB;
			2'd2:    b = 8'hBF;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// "%PDF-" header
	function automatic logic [7:0] pdf_at(input logic [2:0] i);
		logic [7:0] b;
		unique case (i)
			3'd0:    b = 8'h25;
			3'd1:    b = 8'h50;
			3'd2:    b = 8'h44;
			3'd3:    b = 8'h46;
			3'd4:    b = 8'h2D;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[rtl/btc_if.sv]
// Valid/ready channel interfaces for the classifier: byte stream in, verdict out.
// Depends on btc_pkg for widths and the cause type.
`default_nettype none

interface btc_byte_if import btc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [7:0]        data_byte;
	logic              first_byte;
	logic [SLEN_W-1:0] sample_length;

	modport source (output valid, data_byte, first_byte, sample_length, input ready);
	modport sink   (input valid, data_byte, first_byte, sample_length, output ready);
endinterface

interface btc_verdict_if import btc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               looks_binary;
	cause_t             cause;
	logic [TOTAL_W-1:0] suspicious_total;
	logic [AT_W-1:0]    decided_at;

	modport source (output valid, looks_binary, cause, suspicious_total, decided_at,
		input ready);
	modport sink   (input valid, looks_binary, cause, suspicious_total, decided_at,
		output ready);
endinterface

`default_nettype wire

[rtl/binary_text_classifier_core.sv]
// Binary/text classifier: top level tying front end, verdict queue and output stage.
// Depends on btc_pkg, btc_if, btc_front, btc_fifo, btc_back.
//
// Usage:
//   stream  - one buffer byte per beat. Raise first_byte on the opening byte of a
//             buffer together with sample_length (clipped to SAMPLE_LIMIT); a first
//             byte mid-buffer drops the old buffer and restarts.
//   verdict - at most one beat per buffer: looks_binary, cause, suspicious_total and
//             decided_at (index of the deciding byte). An empty buffer answers at once.
// Throughput: one byte per cycle while the queue has room; every counter and flag of
//   the scan updates on the edge that accepts the byte.
// Path: the verdict of the deciding byte is written into the queue on the accepting
//   edge, then loads into the output register once that register is empty or its beat is taken.
// Stall: the queue holds two verdicts; the output register holds a third. stream.ready
//   drops only while the queue is full, so bytes keep flowing until that point.
// Reset: arst_n clears the scan to "waiting for a first byte"; bytes before any first
//   byte, or after the verdict of their buffer, are taken and ignored.
`default_nettype none

module binary_text_classifier_core import btc_pkg::*; #(
	parameter int SAMPLE_LIMIT = SAMPLE_LIMIT_DEF,
	parameter int MIN_EARLY    = MIN_EARLY_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	btc_byte_if.sink      stream,
	btc_verdict_if.source verdict
);

	push_t   push;
	result_t head;
	logic    queue_full, queue_avail, pop;

	// classify bytes; push a verdict only on the deciding beat
	btc_front #(
		.SAMPLE_LIMIT (SAMPLE_LIMIT),
		.MIN_EARLY    (MIN_EARLY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.queue_full (queue_full),
		.push       (push)
	);

	// decouple the scan from the receiver
	btc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_avail),
		.head      (head)
	);

	// hold the beat until the receiver takes it
	btc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.avail   (queue_avail),
		.head    (head),
		.pop     (pop),
		.verdict (verdict)
	);

	// an empty buffer must land in the queue on the next cycle
	a_empty_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		stream.valid && stream.ready && stream.first_byte && stream.sample_length == '0
		|=> queue_avail)
		else $error("empty buffer gave no queued verdict");

	// a BOM verdict is text on the third byte
	a_bom_shape: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.cause == CAUSE_BOM |-> !verdict.looks_binary &&
		verdict.decided_at == AT_W'(2))
		else $error("bad BOM verdict");

	// a PDF verdict is binary on the fifth byte
	a_pdf_shape: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.cause == CAUSE_PDF |-> verdict.looks_binary &&
		verdict.decided_at == AT_W'(4))
		else $error("bad PDF verdict");

	// the front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !queue_full)
		else $error("verdict pushed into full queue");

endmodule

`default_nettype wire

[rtl/btc_front.sv]
// Front end: accepts bytes, runs the BOM/PDF/UTF-8/ratio scan, pushes verdicts.
// Depends on btc_pkg and btc_byte_if.
`default_nettype none

module btc_front import btc_pkg::*; #(
	parameter int SAMPLE_LIMIT = SAMPLE_LIMIT_DEF,
	parameter int MIN_EARLY    = MIN_EARLY_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	btc_byte_if.sink   stream,
	input  wire logic  queue_full,
	output push_t      push
);

	localparam int LEN_W = $clog2(SAMPLE_LIMIT + 1);
	localparam int MUL_W = LEN_W + 4;

	logic [LEN_W-1:0] pos_q, cnt_q, len_q;
	logic             utf8_q, bom_q, pdf_q, vg_q;
	logic [1:0]       pend_q;

	logic [LEN_W-1:0] pos_b, cnt_b, len_b, pos_n, cnt_n, len_sat;
	logic             utf8_b, bom_b, pdf_b, vg_b;
	logic             utf8_n, bom_n, pdf_n, vg_n;
	logic [1:0]       pend_b, pend_n;
	logic             accept, decided, susp, bin;
	cause_t           cause;
	logic [7:0]       d;
	logic [31:0]      total32;

	assign stream.ready = !queue_full;
	assign accept       = stream.valid && stream.ready;
	assign d            = stream.data_byte;
	assign len_sat      = (32'(stream.sample_length) > 32'(SAMPLE_LIMIT)) ?
		LEN_W'(SAMPLE_LIMIT) : LEN_W'(stream.sample_length);

	always_comb begin
		// a first byte restarts the scan for a new buffer, with the clipped sample length
		if (stream.first_byte) begin
			pos_b  = '0;
			cnt_b  = '0;
			len_b  = len_sat;
			utf8_b = 1'b1;
			pend_b = 2'd0;
			bom_b  = 1'b1;
			pdf_b  = 1'b1;
			vg_b   = 1'b0;
		end else begin
			pos_b  = pos_q;
			cnt_b  = cnt_q;
			len_b  = len_q;
			utf8_b = utf8_q;
			pend_b = pend_q;
			bom_b  = bom_q;
			pdf_b  = pdf_q;
			vg_b   = vg_q;
		end

		pos_n   = pos_b;
		cnt_n   = cnt_b;
		utf8_n  = utf8_b;
		pend_n  = pend_b;
		bom_n   = bom_b;
		pdf_n   = pdf_b;
		vg_n    = vg_b;
		decided = 1'b0;
		susp    = 1'b0;
		bin     = 1'b0;
		cause   = CAUSE_EMPTY;

		if (stream.first_byte && len_sat == '0) begin
			decided = 1'b1;
			vg_n    = 1'b1;
		end else if (!vg_b) begin
			if (bom_b) begin
				if (pos_b < LEN_W'(3) && d == bom_at(pos_b[1:0])) begin
					if (pos_b == LEN_W'(2)) begin
						decided = 1'b1;
						cause   = CAUSE_BOM;
					end
				end else begin
					bom_n = 1'b0;
				end
			end
			if (!decided && pdf_b) begin
				if (pos_b < LEN_W'(5) && d == pdf_at(pos_b[2:0])) begin
					if (pos_b == LEN_W'(4)) begin
						decided = 1'b1;
						bin     = 1'b1;
						cause   = CAUSE_PDF;
					end
				end else begin
					pdf_n = 1'b0;
				end
			end

			if (!decided) begin
				priority if (pend_b != 2'd0) begin
					if ((d & CONT_MASK) == CONT_TAG) begin
						pend_n = pend_b - 2'd1;
					end else begin
						utf8_n = 1'b0;
						pend_n = 2'd0;
						susp   = 1'b1;
					end
				end else if (d <= CHAR_PRINT_HI) begin
					priority if (d >= CHAR_PRINT_LO || (d >= CHAR_WS_LO && d <= CHAR_WS_HI)) begin
						susp = 1'b0;
					end else if (d == CHAR_NUL) begin
						decided = 1'b1;
						bin     = 1'b1;
						cause   = CAUSE_NUL;
					end else begin
						susp = 1'b1;
					end
				end else if (d == CHAR_DEL) begin
					susp = 1'b1;
				end else if (utf8_b) begin
					if (d >= LEAD2_LO && d < LEAD_END) begin
						pend_n = (d < LEAD3_LO) ? 2'd1 : ((d < LEAD4_LO) ? 2'd2 : 2'd3);
					end else begin
						utf8_n = 1'b0;
						susp   = 1'b1;
					end
				end else begin
					susp = 1'b1;
				end

				if (susp) begin
					cnt_n = cnt_b + LEN_W'(1);
					if (32'(pos_b) >= 32'(MIN_EARLY) &&
						MUL_W'(cnt_n) * MUL_W'(RATIO_FACTOR) > MUL_W'(len_b)) begin
						decided = 1'b1;
						bin     = 1'b1;
						cause   = CAUSE_EARLY;
					end
				end
			end

			if (!decided && ((LEN_W+1)'(pos_b) + (LEN_W+1)'(1)) >= (LEN_W+1)'(len_b)) begin
				decided = 1'b1;
				bin     = (MUL_W'(cnt_n) * MUL_W'(RATIO_FACTOR) > MUL_W'(len_b));
				cause   = CAUSE_END;
			end

			pos_n = pos_b + LEN_W'(1);
			if (decided) begin
				vg_n = 1'b1;
			end
		end
	end

	assign total32 = 32'(cnt_n);

	always_comb begin
		push.valid                 = accept && decided;
		push.item.looks_binary     = bin;
		push.item.cause            = cause;
		push.item.suspicious_total = (total32 > 32'(TOTAL_MAX)) ?
			TOTAL_W'(TOTAL_MAX) : TOTAL_W'(total32);
		push.item.decided_at       = AT_W'(pos_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cnt_q  <= '0;
			len_q  <= '0;
			utf8_q <= 1'b1;
			pend_q <= 2'd0;
			bom_q  <= 1'b1;
			pdf_q  <= 1'b1;
			vg_q   <= 1'b1;
		end else if (accept) begin
			pos_q  <= pos_n;
			cnt_q  <= cnt_n;
			len_q  <= len_b;
			utf8_q <= utf8_n;
			pend_q <= pend_n;
			bom_q  <= bom_n;
			pdf_q  <= pdf_n;
			vg_q   <= vg_n;
		end
	end

endmodule

`default_nettype wire

[rtl/btc_fifo.sv]
// Short verdict queue between the front end and the output stage.
// Depends on btc_pkg for result_t, push_t and the queue depth.
`default_nettype none

module btc_fifo import btc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output logic       full,
	output logic       not_empty,
	output result_t    head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	result_t          mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push.valid && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem[rd_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= bump(wr_q);
			end
			if (do_pop) begin
				rd_q <= bump(rd_q);
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

[rtl/btc_back.sv]
// Output stage: pulls verdicts from the queue into a register that drives the channel.
// Depends on btc_pkg and btc_verdict_if.
`default_nettype none

module btc_back import btc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     avail,
	input  wire result_t  head,
	output logic          pop,
	btc_verdict_if.source verdict
);

	logic    valid_q;
	result_t item_q;

	// load whenever the queue has a verdict and the register is empty or its beat leaves this cycle
	assign pop = avail && (!valid_q || verdict.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (verdict.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
	end

	assign verdict.valid            = valid_q;
	assign verdict.looks_binary     = item_q.looks_binary;
	assign verdict.cause            = item_q.cause;
	assign verdict.suspicious_total = item_q.suspicious_total;
	assign verdict.decided_at       = item_q.decided_at;

endmodule

`default_nettype wire
